FILE: design/slx_pkg.sv
// shared types, character constants and keyword table for the script lexer
// no dependencies

package slx_pkg;

  localparam int unsigned KW_MAX_LEN  = 6;
  localparam int unsigned KW_NUM      = 9;
  localparam int unsigned KW_TEXT_LEN = 6;
  localparam int unsigned NLEN_W      = $clog2(KW_MAX_LEN + 2);
  localparam int unsigned WIN_IDX_W   = $clog2(KW_MAX_LEN);
  localparam int unsigned MAX_RES     = 3;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_LAMB0  = 8'hCE;
  localparam logic [7:0] CH_LAMB1  = 8'hBB;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_V      = 8'h76;

  // keyword text, first byte in the low bits
  localparam logic [8*KW_TEXT_LEN-1:0] KW_TEXT [KW_NUM] = '{
    48'h0000_0000_6669,
    48'h0000_6E65_6874,
    48'h0000_6573_6C65,
    48'h6164_626D_616C,
    48'h0000_0000_BBCE,
    48'h0000_6575_7274,
    48'h0065_736C_6166,
    48'h0000_0066_6564,
    48'h0000_7473_696C
  };
  localparam int unsigned KW_LEN [KW_NUM] = '{2, 4, 4, 6, 2, 4, 5, 3, 4};

  typedef enum logic [3:0] {
    MODE_IDLE = 4'd0,
    MODE_NUM  = 4'd1,
    MODE_STR  = 4'd2,
    MODE_ESC  = 4'd3,
    MODE_OP   = 4'd4,
    MODE_NAME = 4'd5,
    MODE_CMT  = 4'd6
  } mode_e;

  typedef enum logic [2:0] {
    KIND_NUM  = 3'd0,
    KIND_STR  = 3'd1,
    KIND_OP   = 3'd2,
    KIND_PUNC = 3'd3,
    KIND_VAR  = 3'd4,
    KIND_KW   = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_BYTE = 2'd1,
    ERR_AMP  = 2'd2
  } err_e;

  typedef logic [KW_MAX_LEN-1:0][7:0] win_t;
  typedef logic [NLEN_W-1:0] nlen_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       has_byte;
    logic       token_start;
    logic       token_end;
    kind_e      token_kind;
    logic       is_reference;
    err_e       error_code;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] res;
    logic [1:0]         cnt;
  } bundle_t;

  typedef struct packed {
    logic idle;
    logic held;
  } front_stat_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] value;
  } esc_t;

  function automatic logic is_numeral(logic [7:0] b);
    return b >= CH_0 && b <= CH_9;
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_LF;
  endfunction

  function automatic logic is_name_start(logic [7:0] b);
    return (b >= CH_LA && b <= CH_LZ) || (b >= CH_UA && b <= CH_UZ) ||
           b == CH_UNDER || b == CH_LAMB0 || b == CH_LAMB1;
  endfunction

  function automatic logic is_name(logic [7:0] b);
    return is_name_start(b) || is_numeral(b) || b == CH_QMARK || b == CH_BANG ||
           b == CH_MINUS || b == CH_LT || b == CH_GT || b == CH_EQ;
  endfunction

  function automatic logic is_op(logic [7:0] b);
    return b == CH_PLUS || b == CH_MINUS || b == CH_STAR || b == CH_SLASH ||
           b == CH_PCT || b == CH_EQ || b == CH_AMP || b == CH_PIPE ||
           b == CH_LT || b == CH_GT || b == CH_BANG;
  endfunction

  function automatic logic is_punc(logic [7:0] b);
    return b == CH_COMMA || b == CH_SEMI || b == CH_LPAR || b == CH_RPAR ||
           b == CH_LBRACE || b == CH_RBRACE || b == CH_LBRACK || b == CH_RBRACK;
  endfunction

  function automatic esc_t map_escape(logic [7:0] b);
    esc_t e;
    e.ok    = 1'b1;
    e.value = b;
    case (b)
      CH_N:      e.value = 8'h0A;
      CH_T:      e.value = 8'h09;
      CH_A:      e.value = 8'h07;
      CH_B:      e.value = 8'h08;
      CH_F:      e.value = 8'h0C;
      CH_R:      e.value = 8'h0D;
      CH_V:      e.value = 8'h0B;
      CH_BSLASH, CH_SQUOTE, CH_DQUOTE, CH_QMARK, CH_NUL: e.value = b;
      default: begin
        e.ok    = 1'b0;
        e.value = 8'h00;
      end
    endcase
    return e;
  endfunction

  function automatic logic [7:0] kw_byte(int unsigned k, int unsigned i);
    logic [7:0] r;
    r = 8'h00;
    if (i < KW_TEXT_LEN) begin
      r = KW_TEXT[k][8*i +: 8];
    end
    return r;
  endfunction

  function automatic kind_e name_kind(win_t win, nlen_t len);
    kind_e k;
    logic  match;
    k = KIND_VAR;
    if (len <= NLEN_W'(KW_MAX_LEN)) begin
      for (int unsigned w = 0; w < KW_NUM; w++) begin
        match = (len == NLEN_W'(KW_LEN[w]));
        for (int unsigned i = 0; i < KW_MAX_LEN; i++) begin
          if (NLEN_W'(i) < len && win[i] != kw_byte(w, i)) begin
            match = 1'b0;
          end
        end
        if (match) begin
          k = KIND_KW;
        end
      end
    end
    return k;
  endfunction

  function automatic res_t mk_res(logic [7:0] b, logic has, logic st, logic en,
                                  kind_e kind, logic rf, err_e err);
    res_t r;
    r.text_byte    = b;
    r.has_byte     = has;
    r.token_start  = st;
    r.token_end    = en;
    r.token_kind   = kind;
    r.is_reference = rf;
    r.error_code   = err;
    return r;
  endfunction

endpackage

FILE: design/script_lexer_stream.sv
// top level of the byte-serial script lexer: front end, bundle queue and
// back end; uses slx_pkg, slx_front, slx_queue and slx_back
//
// channel   dir  word                               marker
// s_axis    in   tdata[7:0] src_byte                tlast end_of_input
// m_axis    out  tdata[7:0] text_byte, [8] start    tlast token_end
//                tuser has_byte, kind, is_reference, error_code
//
// one source byte is taken per cycle while the four-entry bundle queue has room
// each byte yields zero to three results; the back end sends one result a cycle while m_axis accepts
// so the output port sets the long-run rate for bytes that make several results
// reset clears the lexer state, the queue pointers and the output valid flag
// a stall on m_axis fills the queue and then drops s_axis_tready_o

module script_lexer_stream (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // src_byte
  input  logic        s_axis_tlast_i,   // end_of_input
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // text_byte, token_start
  output logic        m_axis_tlast_o,   // token_end
  output logic [6:0]  m_axis_tuser_o    // has_byte, token_kind, is_reference, error_code
);
  import slx_pkg::*;

  logic        push, full, pop, q_valid;
  bundle_t     bundle, head;
  front_stat_t stat;
  res_t        res;

  slx_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (s_axis_tvalid_i),
    .src_byte_i     (s_axis_tdata_i),
    .end_of_input_i (s_axis_tlast_i),
    .space_i        (!full),
    .push_o         (push),
    .bundle_o       (bundle),
    .stat_o         (stat)
  );

  slx_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .bundle_i (bundle),
    .full_o   (full),
    .pop_i    (pop),
    .valid_o  (q_valid),
    .head_o   (head)
  );

  slx_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_o        (res)
  );

  assign s_axis_tready_o = !full;
  assign m_axis_tdata_o  = {7'b0, res.token_start, res.text_byte};
  assign m_axis_tlast_o  = res.token_end;
  assign m_axis_tuser_o  = {res.error_code, res.is_reference, res.token_kind, res.has_byte};

  a_pop_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("queue popped while empty");

  a_head_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid |-> head.cnt != 2'd0)
    else $error("queued bundle without results");

  a_eoi_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> stat.idle && !stat.held)
    else $error("lexer not idle after end of input");

endmodule

FILE: design/slx_front.sv
// front end: classifies each source byte against the lexer state and
// builds the bundle of up to three results it causes; uses slx_pkg

module slx_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [7:0]          src_byte_i,
  input  logic                end_of_input_i,
  input  logic                space_i,
  output logic                push_o,
  output slx_pkg::bundle_t    bundle_o,
  output slx_pkg::front_stat_t stat_o
);
  import slx_pkg::*;

  mode_e      mode_q, mode_d;
  logic       dot_q, dot_d;
  logic [7:0] hbyte_q, hbyte_d;
  logic       hvalid_q, hvalid_d;
  win_t       win_q, win_d;
  nlen_t      nlen_q, nlen_d;
  logic       ref_q, ref_d;

  res_t       res [MAX_RES];
  logic [1:0] n;
  logic       do_close, do_idle, do_name, name_ref;
  kind_e      close_kind;
  esc_t       esc;
  logic [7:0] b;
  logic       accept;

  assign b      = src_byte_i;
  assign accept = valid_i && space_i;

  always_comb begin
    mode_d     = mode_q;
    dot_d      = dot_q;
    hbyte_d    = hbyte_q;
    hvalid_d   = hvalid_q;
    win_d      = win_q;
    nlen_d     = nlen_q;
    ref_d      = ref_q;
    n          = 2'd0;
    do_close   = 1'b0;
    do_idle    = 1'b0;
    do_name    = 1'b0;
    name_ref   = 1'b0;
    close_kind = KIND_NUM;
    esc        = map_escape(b);
    for (int i = 0; i < MAX_RES; i++) begin
      res[i] = '0;
    end

    if (end_of_input_i) begin
      if (hvalid_q) begin
        hvalid_d = 1'b0;
        if (hbyte_q == CH_MINUS) begin
          res[n] = mk_res(CH_MINUS, 1'b1, 1'b1, 1'b1, KIND_OP, 1'b0, ERR_NONE);
          n = n + 2'd1;
        end else begin
          res[n] = mk_res(CH_AMP, 1'b0, 1'b0, 1'b0, KIND_NUM, 1'b0, ERR_AMP);
          n = n + 2'd1;
        end
      end
      do_close = 1'b1;
    end else begin
      case (mode_q)
        MODE_IDLE: begin
          if (hvalid_q) begin
            hvalid_d = 1'b0;
            if (hbyte_q == CH_MINUS) begin
              if (is_numeral(b)) begin
                mode_d = MODE_NUM;
                dot_d  = 1'b0;
                res[n] = mk_res(CH_MINUS, 1'b1, 1'b1, 1'b0, KIND_NUM, 1'b0, ERR_NONE);
                n = n + 2'd1;
                res[n] = mk_res(b, 1'b1, 1'b0, 1'b0, KIND_NUM, 1'b0, ERR_NONE);
                n = n + 2'd1;
              end else begin
                mode_d = MODE_OP;
                res[n] = mk_res(CH_MINUS, 1'b1, 1'b1, 1'b0, KIND_OP, 1'b0, ERR_NONE);
                n = n + 2'd1;
                if (is_op(b)) begin
                  res[n] = mk_res(b, 1'b1, 1'b0, 1'b0, KIND_OP, 1'b0, ERR_NONE);
                  n = n + 2'd1;
                end else begin
                  do_close = 1'b1;
                  do_idle  = 1'b1;
                end
              end
            end else begin
              if (is_op(b)) begin
                mode_d = MODE_OP;
                res[n] = mk_res(CH_AMP, 1'b1, 1'b1, 1'b0, KIND_OP, 1'b0, ERR_NONE);
                n = n + 2'd1;
                res[n] = mk_res(b, 1'b1, 1'b0, 1'b0, KIND_OP, 1'b0, ERR_NONE);
                n = n + 2'd1;
              end else if (is_name_start(b)) begin
                do_name  = 1'b1;
                name_ref = 1'b1;
              end else begin
                res[n] = mk_res(CH_AMP, 1'b0, 1'b0, 1'b0, KIND_NUM, 1'b0, ERR_AMP);
                n = n + 2'd1;
                do_idle = 1'b1;
              end
            end
          end else begin
            do_idle = 1'b1;
          end
        end
        MODE_CMT: begin
          if (b == CH_LF) begin
            mode_d = MODE_IDLE;
          end
        end
        MODE_NUM: begin
          if (is_numeral(b) || (b == CH_DOT && !dot_q)) begin
            if (b == CH_DOT) begin
              dot_d = 1'b1;
            end
            res[n] = mk_res(b, 1'b1, 1'b0, 1'b0, KIND_NUM, 1'b0, ERR_NONE);
            n = n + 2'd1;
          end else begin
            do_close = 1'b1;
            do_idle  = 1'b1;
          end
        end
        MODE_STR: begin
          if (b == CH_BSLASH) begin
            mode_d = MODE_ESC;
          end else if (b == CH_DQUOTE) begin
            do_close = 1'b1;
          end else begin
            res[n] = mk_res(b, 1'b1, 1'b0, 1'b0, KIND_STR, 1'b0, ERR_NONE);
            n = n + 2'd1;
          end
        end
        MODE_ESC: begin
          if (esc.ok) begin
            res[n] = mk_res(esc.value, 1'b1, 1'b0, 1'b0, KIND_STR, 1'b0, ERR_NONE);
            n = n + 2'd1;
          end
          mode_d = MODE_STR;
        end
        MODE_OP: begin
          if (is_op(b)) begin
            res[n] = mk_res(b, 1'b1, 1'b0, 1'b0, KIND_OP, 1'b0, ERR_NONE);
            n = n + 2'd1;
          end else begin
            do_close = 1'b1;
            do_idle  = 1'b1;
          end
        end
        MODE_NAME: begin
          if (is_name(b)) begin
            if (nlen_q < NLEN_W'(KW_MAX_LEN)) begin
              win_d[nlen_q[WIN_IDX_W-1:0]] = b;
            end
            if (nlen_q <= NLEN_W'(KW_MAX_LEN)) begin
              nlen_d = nlen_q + NLEN_W'(1);
            end
            res[n] = mk_res(b, 1'b1, 1'b0, 1'b0, KIND_VAR, ref_q, ERR_NONE);
            n = n + 2'd1;
          end else begin
            do_close = 1'b1;
            do_idle  = 1'b1;
          end
        end
        default: begin
          mode_d  = MODE_IDLE;
          do_idle = 1'b1;
        end
      endcase
    end

    if (do_close) begin
      case (mode_d)
        MODE_STR, MODE_ESC: close_kind = KIND_STR;
        MODE_OP:            close_kind = KIND_OP;
        MODE_NAME:          close_kind = name_kind(win_d, nlen_d);
        default:            close_kind = KIND_NUM;
      endcase
      if (mode_d != MODE_IDLE && mode_d != MODE_CMT) begin
        res[n] = mk_res(8'h00, 1'b0, 1'b0, 1'b1, close_kind, ref_d, ERR_NONE);
        n = n + 2'd1;
      end
      mode_d = MODE_IDLE;
      dot_d  = 1'b0;
      ref_d  = 1'b0;
    end

    if (do_idle && !is_space(b)) begin
      if (b == CH_HASH) begin
        mode_d = MODE_CMT;
      end else if (b == CH_DQUOTE) begin
        mode_d = MODE_STR;
        res[n] = mk_res(8'h00, 1'b0, 1'b1, 1'b0, KIND_STR, 1'b0, ERR_NONE);
        n = n + 2'd1;
      end else if (b == CH_MINUS || b == CH_AMP) begin
        hbyte_d  = b;
        hvalid_d = 1'b1;
      end else if (is_numeral(b)) begin
        mode_d = MODE_NUM;
        dot_d  = 1'b0;
        res[n] = mk_res(b, 1'b1, 1'b1, 1'b0, KIND_NUM, 1'b0, ERR_NONE);
        n = n + 2'd1;
      end else if (is_name_start(b)) begin
        do_name  = 1'b1;
        name_ref = 1'b0;
      end else if (is_punc(b)) begin
        res[n] = mk_res(b, 1'b1, 1'b1, 1'b1, KIND_PUNC, 1'b0, ERR_NONE);
        n = n + 2'd1;
      end else if (is_op(b)) begin
        mode_d = MODE_OP;
        res[n] = mk_res(b, 1'b1, 1'b1, 1'b0, KIND_OP, 1'b0, ERR_NONE);
        n = n + 2'd1;
      end else begin
        res[n] = mk_res(b, 1'b0, 1'b0, 1'b0, KIND_NUM, 1'b0, ERR_BYTE);
        n = n + 2'd1;
      end
    end

    if (do_name) begin
      win_d    = '0;
      win_d[0] = b;
      nlen_d   = NLEN_W'(1);
      ref_d    = name_ref;
      mode_d   = MODE_NAME;
      res[n] = mk_res(b, 1'b1, 1'b1, 1'b0, KIND_VAR, name_ref, ERR_NONE);
      n = n + 2'd1;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_RES; i++) begin
      bundle_o.res[i] = res[i];
    end
    bundle_o.cnt = n;
  end

  assign push_o      = accept && (n != 2'd0);
  assign stat_o.idle = (mode_q == MODE_IDLE);
  assign stat_o.held = hvalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      dot_q    <= 1'b0;
      hbyte_q  <= 8'h00;
      hvalid_q <= 1'b0;
      win_q    <= '0;
      nlen_q   <= '0;
      ref_q    <= 1'b0;
    end else if (accept) begin
      mode_q   <= mode_d;
      dot_q    <= dot_d;
      hbyte_q  <= hbyte_d;
      hvalid_q <= hvalid_d;
      win_q    <= win_d;
      nlen_q   <= nlen_d;
      ref_q    <= ref_d;
    end
  end

endmodule

FILE: design/slx_queue.sv
// short bundle queue between the front and back ends
// uses slx_pkg for the bundle type and depth

module slx_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  slx_pkg::bundle_t bundle_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output slx_pkg::bundle_t head_o
);
  import slx_pkg::*;

  bundle_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_q, wr_d;
  logic [QPTR_W-1:0]   rd_q, rd_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= bundle_i;
    end
  end

endmodule

FILE: design/slx_back.sv
// back end: walks the results of the head bundle one per cycle into the
// output register while it is empty or being read; uses slx_pkg

module slx_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  slx_pkg::bundle_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output slx_pkg::res_t    out_o
);
  import slx_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       ov_q, ov_d;
  res_t       out_q;
  logic       load, last;

  assign load  = head_valid_i && (!ov_q || out_ready_i);
  assign last  = (idx_q == head_i.cnt - 2'd1);
  assign pop_o = load && last;

  always_comb begin
    idx_d = idx_q;
    ov_d  = ov_q;
    if (load) begin
      ov_d  = 1'b1;
      idx_d = last ? 2'd0 : idx_q + 2'd1;
    end else if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
      ov_q  <= 1'b0;
    end else begin
      idx_q <= idx_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= head_i.res[idx_q];
    end
  end

  assign out_valid_o = ov_q;
  assign out_o       = out_q;

endmodule

FILE: sim/script_lexer_stream_tb.sv
// self-checking testbench for script_lexer_stream: drives source bytes, predicts
// the token words in a behavioral lexer and checks each output word in order
// depends on slx_pkg and script_lexer_stream

module script_lexer_stream_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slx_pkg::*;

  localparam string DIGITS     = "0123456789";
  localparam string LEADS      = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  localparam string NAME_CHARS = "abcdefghijklmnopqrstuvwxyzQZ_0123456789?!-<>=";
  localparam string OPERATORS  = "+-*/%=&|<>!";
  localparam string PUNCTS     = ",;(){}[]";
  localparam string BLANKS     = " \t\n";
  localparam string ESCAPES    = "ntabfrv\\'\"?";
  localparam int    DRAIN_CYCLES = 20;

  logic        clk_i;
  logic        rst_ni  = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data  = 8'h00;
  logic        s_last  = 1'b0;
  logic        m_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [15:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic [6:0]  m_axis_tuser_o;

  // expected token words, oldest first
  res_t        token_q [$];
  logic [7:0]  frag_q [$];
  int          err_count = 0;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;
  int unsigned rx_hold   = 0;

  // lexer state mirror
  mode_e       lx_mode   = MODE_IDLE;
  logic        lx_dot    = 1'b0;
  logic [7:0]  lx_held   = 8'h00;
  logic        lx_held_v = 1'b0;
  logic [7:0]  lx_win [KW_MAX_LEN];
  int unsigned lx_len    = 0;
  logic        lx_ref    = 1'b0;

  script_lexer_stream dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic chr_digit(logic [7:0] b);
    return b >= CH_0 && b <= CH_9;
  endfunction

  function automatic logic chr_blank(logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_LF;
  endfunction

  function automatic logic chr_lead(logic [7:0] b);
    return (b >= CH_LA && b <= CH_LZ) || (b >= CH_UA && b <= CH_UZ) || b == CH_UNDER ||
           b == CH_LAMB0 || b == CH_LAMB1;
  endfunction

  function automatic logic chr_word(logic [7:0] b);
    return chr_lead(b) || chr_digit(b) || b == CH_QMARK || b == CH_BANG || b == CH_MINUS ||
           b == CH_LT || b == CH_GT || b == CH_EQ;
  endfunction

  function automatic logic chr_oper(logic [7:0] b);
    case (b)
      CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT, CH_EQ, CH_AMP, CH_PIPE, CH_LT, CH_GT,
      CH_BANG: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic chr_punct(logic [7:0] b);
    case (b)
      CH_COMMA, CH_SEMI, CH_LPAR, CH_RPAR, CH_LBRACE, CH_RBRACE, CH_LBRACK,
      CH_RBRACK: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic unescape(logic [7:0] b, output logic [7:0] v);
    unescape = 1'b1;
    v = b;
    case (b)
      CH_N: v = 8'h0A;
      CH_T: v = 8'h09;
      CH_A: v = 8'h07;
      CH_B: v = 8'h08;
      CH_F: v = 8'h0C;
      CH_R: v = 8'h0D;
      CH_V: v = 8'h0B;
      CH_BSLASH, CH_SQUOTE, CH_DQUOTE, CH_QMARK, CH_NUL: v = b;
      default: begin
        unescape = 1'b0;
        v = 8'h00;
      end
    endcase
  endfunction

  function automatic void push_word(logic [7:0] b, logic has, logic st, logic en, kind_e k,
                                    logic rf, err_e e);
    res_t r;
    r.text_byte    = b;
    r.has_byte     = has;
    r.token_start  = st;
    r.token_end    = en;
    r.token_kind   = k;
    r.is_reference = rf;
    r.error_code   = e;
    token_q.push_back(r);
  endfunction

  function automatic kind_e word_kind();
    kind_e k;
    logic  hit;
    k = KIND_VAR;
    if (lx_len <= KW_MAX_LEN) begin
      for (int w = 0; w < KW_NUM; w++) begin
        if (KW_LEN[w] == lx_len) begin
          hit = 1'b1;
          for (int i = 0; i < lx_len; i++) begin
            if (lx_win[i] != KW_TEXT[w][8*i +: 8]) hit = 1'b0;
          end
          if (hit) k = KIND_KW;
        end
      end
    end
    return k;
  endfunction

  function automatic void grow_name(logic [7:0] b);
    if (lx_len < KW_MAX_LEN) lx_win[lx_len] = b;
    if (lx_len <= KW_MAX_LEN) lx_len++;
  endfunction

  function automatic void start_name(logic [7:0] b, logic rf);
    foreach (lx_win[i]) lx_win[i] = 8'h00;
    lx_len = 0;
    lx_ref = rf;
    grow_name(b);
    lx_mode = MODE_NAME;
    push_word(b, 1'b1, 1'b1, 1'b0, KIND_VAR, rf, ERR_NONE);
  endfunction

  function automatic void close_tok();
    kind_e k;
    k = KIND_NUM;
    if (lx_mode == MODE_STR || lx_mode == MODE_ESC) k = KIND_STR;
    else if (lx_mode == MODE_OP) k = KIND_OP;
    else if (lx_mode == MODE_NAME) k = word_kind();
    if (lx_mode != MODE_IDLE && lx_mode != MODE_CMT)
      push_word(8'h00, 1'b0, 1'b0, 1'b1, k, lx_ref, ERR_NONE);
    lx_mode = MODE_IDLE;
    lx_dot  = 1'b0;
    lx_ref  = 1'b0;
  endfunction

  function automatic void lex_fresh(logic [7:0] b);
    if (chr_blank(b)) begin
    end else if (b == CH_HASH) begin
      lx_mode = MODE_CMT;
    end else if (b == CH_DQUOTE) begin
      lx_mode = MODE_STR;
      push_word(8'h00, 1'b0, 1'b1, 1'b0, KIND_STR, 1'b0, ERR_NONE);
    end else if (b == CH_MINUS || b == CH_AMP) begin
      lx_held   = b;
      lx_held_v = 1'b1;
    end else if (chr_digit(b)) begin
      lx_mode = MODE_NUM;
      lx_dot  = 1'b0;
      push_word(b, 1'b1, 1'b1, 1'b0, KIND_NUM, 1'b0, ERR_NONE);
    end else if (chr_lead(b)) begin
      start_name(b, 1'b0);
    end else if (chr_punct(b)) begin
      push_word(b, 1'b1, 1'b1, 1'b1, KIND_PUNC, 1'b0, ERR_NONE);
    end else if (chr_oper(b)) begin
      lx_mode = MODE_OP;
      push_word(b, 1'b1, 1'b1, 1'b0, KIND_OP, 1'b0, ERR_NONE);
    end else begin
      push_word(b, 1'b0, 1'b0, 1'b0, KIND_NUM, 1'b0, ERR_BYTE);
    end
  endfunction

  function automatic void resolve_pending(logic [7:0] b);
    lx_held_v = 1'b0;
    if (lx_held == CH_MINUS) begin
      if (chr_digit(b)) begin
        lx_mode = MODE_NUM;
        lx_dot  = 1'b0;
        push_word(CH_MINUS, 1'b1, 1'b1, 1'b0, KIND_NUM, 1'b0, ERR_NONE);
        push_word(b, 1'b1, 1'b0, 1'b0, KIND_NUM, 1'b0, ERR_NONE);
      end else begin
        lx_mode = MODE_OP;
        push_word(CH_MINUS, 1'b1, 1'b1, 1'b0, KIND_OP, 1'b0, ERR_NONE);
        if (chr_oper(b)) begin
          push_word(b, 1'b1, 1'b0, 1'b0, KIND_OP, 1'b0, ERR_NONE);
        end else begin
          close_tok();
          lex_fresh(b);
        end
      end
    end else if (chr_oper(b)) begin
      lx_mode = MODE_OP;
      push_word(CH_AMP, 1'b1, 1'b1, 1'b0, KIND_OP, 1'b0, ERR_NONE);
      push_word(b, 1'b1, 1'b0, 1'b0, KIND_OP, 1'b0, ERR_NONE);
    end else if (chr_lead(b)) begin
      start_name(b, 1'b1);
    end else begin
      push_word(CH_AMP, 1'b0, 1'b0, 1'b0, KIND_NUM, 1'b0, ERR_AMP);
      lex_fresh(b);
    end
  endfunction

  // advances the lexer mirror by one accepted word and queues what it emits
  function automatic void lex_byte(logic [7:0] b, logic eoi);
    logic [7:0] v;
    if (eoi) begin
      if (lx_held_v) begin
        lx_held_v = 1'b0;
        if (lx_held == CH_MINUS)
          push_word(CH_MINUS, 1'b1, 1'b1, 1'b1, KIND_OP, 1'b0, ERR_NONE);
        else
          push_word(CH_AMP, 1'b0, 1'b0, 1'b0, KIND_NUM, 1'b0, ERR_AMP);
      end
      close_tok();
    end else begin
      case (lx_mode)
        MODE_IDLE: begin
          if (lx_held_v) resolve_pending(b);
          else lex_fresh(b);
        end
        MODE_CMT: begin
          if (b == CH_LF) lx_mode = MODE_IDLE;
        end
        MODE_NUM: begin
          if (chr_digit(b) || (b == CH_DOT && !lx_dot)) begin
            if (b == CH_DOT) lx_dot = 1'b1;
            push_word(b, 1'b1, 1'b0, 1'b0, KIND_NUM, 1'b0, ERR_NONE);
          end else begin
            close_tok();
            lex_fresh(b);
          end
        end
        MODE_STR: begin
          if (b == CH_BSLASH) lx_mode = MODE_ESC;
          else if (b == CH_DQUOTE) close_tok();
          else push_word(b, 1'b1, 1'b0, 1'b0, KIND_STR, 1'b0, ERR_NONE);
        end
        MODE_ESC: begin
          if (unescape(b, v)) push_word(v, 1'b1, 1'b0, 1'b0, KIND_STR, 1'b0, ERR_NONE);
          lx_mode = MODE_STR;
        end
        MODE_OP: begin
          if (chr_oper(b)) begin
            push_word(b, 1'b1, 1'b0, 1'b0, KIND_OP, 1'b0, ERR_NONE);
          end else begin
            close_tok();
            lex_fresh(b);
          end
        end
        MODE_NAME: begin
          if (chr_word(b)) begin
            grow_name(b);
            push_word(b, 1'b1, 1'b0, 1'b0, KIND_VAR, lx_ref, ERR_NONE);
          end else begin
            close_tok();
            lex_fresh(b);
          end
        end
        default: begin
          lx_mode = MODE_IDLE;
          lex_fresh(b);
        end
      endcase
    end
  endfunction

  function automatic void check_field(string fname, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", fname, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      if (token_q.size() == 0) begin
        $error("output word with nothing expected: tdata %0h", m_axis_tdata_o);
        err_count++;
      end else begin
        want = token_q.pop_front();
        check_field("text_byte", want.text_byte, m_axis_tdata_o[7:0]);
        check_field("token_start", want.token_start, m_axis_tdata_o[8]);
        check_field("token_end", want.token_end, m_axis_tlast_o);
        check_field("has_byte", want.has_byte, m_axis_tuser_o[0]);
        check_field("token_kind", want.token_kind, m_axis_tuser_o[3:1]);
        check_field("is_reference", want.is_reference, m_axis_tuser_o[4]);
        check_field("error_code", want.error_code, m_axis_tuser_o[6:5]);
      end
    end
  end

  // output side: random stalls, quiet stretches and requested long holds
  initial begin
    int unsigned gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(31, 0) == 0) rx_steady = !rx_steady;
      if (rx_hold > 0) begin
        gap = rx_hold;
        rx_hold = 0;
      end else begin
        gap = rx_steady ? 0 : $urandom_range(16, 0);
      end
      if (gap > 0) begin
        m_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  task automatic send_word(input logic [7:0] b, input logic eoi);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(16, 0);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    s_last  <= eoi;
    do @(posedge clk_i); while (!s_axis_tready_o);
    lex_byte(b, eoi);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  task automatic hold_until_drained();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (token_q.size() != 0);
  endtask

  function automatic logic [7:0] pick_char(string set);
    return set[$urandom_range(set.len() - 1, 0)];
  endfunction

  function automatic logic [7:0] any_but(logic [7:0] a, logic [7:0] b);
    logic [7:0] c;
    c = 8'($urandom_range(255, 0));
    if (c == a || c == b) c = CH_SPACE;
    return c;
  endfunction

  // mostly well-formed tokens with random content, some noise
  function automatic void build_fragment();
    int unsigned sel;
    int unsigned k;
    sel = $urandom_range(19, 0);
    frag_q.delete();
    case (sel)
      0, 1, 2: begin
        if ($urandom_range(2, 0) == 0) frag_q.push_back(CH_MINUS);
        repeat ($urandom_range(3, 1)) frag_q.push_back(pick_char(DIGITS));
        if ($urandom_range(1, 0)) begin
          frag_q.push_back(CH_DOT);
          repeat ($urandom_range(2, 0)) frag_q.push_back(pick_char(DIGITS));
        end
        if ($urandom_range(3, 0) == 0) frag_q.push_back(CH_DOT);
      end
      3, 4, 5: begin
        frag_q.push_back(CH_DQUOTE);
        repeat ($urandom_range(6, 0)) begin
          if ($urandom_range(2, 0) == 0) begin
            frag_q.push_back(CH_BSLASH);
            if ($urandom_range(5, 0) == 0) frag_q.push_back(8'($urandom_range(255, 0)));
            else if ($urandom_range(11, 0) == 0) frag_q.push_back(CH_NUL);
            else frag_q.push_back(pick_char(ESCAPES));
          end else begin
            frag_q.push_back(any_but(CH_DQUOTE, CH_BSLASH));
          end
        end
        if ($urandom_range(7, 0) != 0) frag_q.push_back(CH_DQUOTE);
      end
      6, 7: begin
        repeat ($urandom_range(3, 1)) frag_q.push_back(pick_char(OPERATORS));
      end
      8, 9: frag_q.push_back(pick_char(PUNCTS));
      10, 11, 12, 13: begin
        if ($urandom_range(2, 0) == 0) frag_q.push_back(CH_AMP);
        if ($urandom_range(3, 0) == 0) begin
          k = $urandom_range(KW_NUM - 1, 0);
          for (int i = 0; i < KW_LEN[k]; i++) frag_q.push_back(KW_TEXT[k][8*i +: 8]);
          if ($urandom_range(2, 0) == 0) frag_q.push_back(pick_char(NAME_CHARS));
        end else begin
          if ($urandom_range(7, 0) == 0)
            frag_q.push_back($urandom_range(1, 0) ? CH_LAMB0 : CH_LAMB1);
          else
            frag_q.push_back(pick_char(LEADS));
          repeat ($urandom_range(8, 0)) frag_q.push_back(pick_char(NAME_CHARS));
        end
      end
      14: begin
        frag_q.push_back(CH_HASH);
        repeat ($urandom_range(5, 0)) frag_q.push_back(any_but(CH_LF, CH_LF));
        if ($urandom_range(7, 0) != 0) frag_q.push_back(CH_LF);
      end
      15: frag_q.push_back(pick_char(BLANKS));
      16, 17: begin
        frag_q.push_back($urandom_range(1, 0) ? CH_MINUS : CH_AMP);
        frag_q.push_back(8'($urandom_range(255, 0)));
      end
      18: begin
        frag_q.push_back(CH_MINUS);
        repeat ($urandom_range(2, 1)) frag_q.push_back(pick_char(OPERATORS));
      end
      default: frag_q.push_back(8'($urandom_range(255, 0)));
    endcase
    if ($urandom_range(1, 0)) frag_q.push_back(pick_char(BLANKS));
  endfunction

  task automatic test_token_edges();
    send_text("-9.5.");
    send_text("&x&;");
    send_text("\"\\q\\n\"");
    send_text("if ");
    send_word(8'hFF, 1'b0);
    send_word(CH_LAMB0, 1'b0);
    send_word(CH_LAMB1, 1'b0);
    send_word(CH_SEMI, 1'b0);
    send_word(CH_MINUS, 1'b0);
    send_word(8'h00, 1'b1);
    send_word(CH_AMP, 1'b0);
    send_word(8'hA5, 1'b1);
  endtask

  task automatic test_random_source(input int unsigned n_words);
    int unsigned sent;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(5, 0) == 0) tx_steady = !tx_steady;
      build_fragment();
      while (frag_q.size() != 0) begin
        send_word(frag_q.pop_front(), 1'b0);
        sent++;
      end
      if ($urandom_range(24, 0) == 0) begin
        send_word(8'($urandom_range(255, 0)), 1'b1);
        sent++;
      end
    end
    tx_steady = 1'b0;
  endtask

  task automatic test_output_stall();
    rx_hold   = 150;
    tx_steady = 1'b1;
    repeat (12) send_text("-a ");
    tx_steady = 1'b0;
  endtask

  task automatic test_drain_pause();
    send_text("x=-1;");
    hold_until_drained();
    send_text("&def(2.5)\n");
    hold_until_drained();
  endtask

  initial begin
    foreach (lx_win[i]) lx_win[i] = 8'h00;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_token_edges();
    test_random_source(295);
    test_output_stall();
    test_drain_pause();
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0 && token_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
